[rtl/core/xcs_pkg.sv]
// Shared constants, types and helpers for the XMODEM checksum sender.
// Depends on nothing; used by xmodem_checksum_sender.
package xcs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int SIDX_W      = $clog2(BLOCK_BYTES + 4);

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_REPLY   = 3'd1;
  localparam logic [2:0] CMD_TIMEOUT = 3'd2;
  localparam logic [2:0] CMD_FILE    = 3'd3;
  localparam logic [2:0] CMD_SLOT    = 3'd4;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_WAIT_START = 3'd1;
  localparam logic [2:0] ST_LOAD       = 3'd2;
  localparam logic [2:0] ST_SEND       = 3'd3;
  localparam logic [2:0] ST_WAIT_REPLY = 3'd4;
  localparam logic [2:0] ST_DONE       = 3'd5;
  localparam logic [2:0] ST_ERROR      = 3'd6;

  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_START_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_TRANSFER      = 2'd2;

  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_PAD_VALUE   = 2'd1;
  localparam logic [1:0] CFG_START_VALUE = 2'd2;

  localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;
  localparam logic [7:0] PAD_VALUE_RST   = 8'h1A;
  localparam logic [7:0] START_VALUE_RST = 8'h33;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_WAIT_START = 7'b0000010,
    PH_LOAD       = 7'b0000100,
    PH_SEND       = 7'b0001000,
    PH_WAIT_REPLY = 7'b0010000,
    PH_DONE       = 7'b0100000,
    PH_ERROR      = 7'b1000000
  } phase_t;

  // one result between the state stage and the output register
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        sel_mem;
    logic        frame_end;
    logic [2:0]  status;
    logic [1:0]  error_kind;
    logic [15:0] acked;
    logic [15:0] resent;
    logic [15:0] sent;
  } result_t;

  function automatic logic [2:0] status_of(input phase_t ph);
    logic [2:0] st;
    unique case (ph)
      PH_IDLE:       st = ST_IDLE;
      PH_WAIT_START: st = ST_WAIT_START;
      PH_LOAD:       st = ST_LOAD;
      PH_SEND:       st = ST_SEND;
      PH_WAIT_REPLY: st = ST_WAIT_REPLY;
      PH_DONE:       st = ST_DONE;
      PH_ERROR:      st = ST_ERROR;
      default:       st = ST_IDLE;
    endcase
    return st;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

[rtl/core/xmodem_checksum_sender.sv]
// XMODEM checksum sender: protocol sequencer around a synchronous block buffer.
// Depends on xcs_pkg.
//
//   channel | signals                                          | transfer when
//   --------+--------------------------------------------------+----------------------
//   in      | in_command, in_data_byte, in_final_byte          | in_valid & in_ready
//   out     | out_tx_valid .. out_blocks_sent (8 fields)        | out_valid & out_ready
//   cfg     | cfg_index, cfg_data                              | cfg_we
//
// One item per cycle sustained while the output is not stalled. An item updates the
// sequencer state in the cycle it is taken; a data byte is read into the buffer read
// register as the result is registered, then the result moves to the output register.
// Synchronous active-low reset; the buffer itself is not cleared.
// A stalled output holds one result and one more in flight before in_ready drops.
module xmodem_checksum_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_value,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic [1:0]  out_error_kind,
  output logic [15:0] out_blocks_acked,
  output logic [15:0] out_blocks_resent,
  output logic [15:0] out_blocks_sent,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = xcs_pkg::ADDR_W;
  localparam int FW = xcs_pkg::FILL_W;
  localparam int SW = xcs_pkg::SIDX_W;

  // configuration
  logic [3:0] retry_limit_r;
  logic [7:0] pad_value_r;
  logic [7:0] start_value_r;

  // sequencer state
  xcs_pkg::phase_t phase_r, phase_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [7:0]    blk_r, blk_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [3:0]    retry_r, retry_nxt;
  logic          final_r, final_nxt;
  logic          eot_r, eot_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [15:0]   ack_r, ack_nxt;
  logic [15:0]   resend_r, resend_nxt;
  logic [15:0]   sent_r, sent_nxt;
  logic [7:0]    pad_hold_r, pad_hold_nxt;

  // block buffer
  logic [7:0]    mem [xcs_pkg::BLOCK_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    rd_r;

  // pipeline
  xcs_pkg::result_t res, p1_r;
  logic p1_v_r, p1_v_nxt, p1_adv;
  logic out_valid_r, out_valid_nxt;
  logic in_fire;

  logic [FW-1:0] fill_inc, rem;
  logic [7:0]    sum_add;
  logic [15:0]   pad_prod;
  logic [SW-1:0] data_idx;
  logic [3:0]    retry_inc;

  assign p1_adv   = p1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !p1_v_r || p1_adv;
  assign in_fire  = in_valid && in_ready;

  assign fill_inc  = fill_r + FW'(1);
  assign rem       = FW'(xcs_pkg::BLOCK_BYTES) - fill_inc;
  assign sum_add   = sum_r + in_data_byte;
  assign pad_prod  = pad_value_r * rem[7:0];  // only the low byte counts mod 256
  assign data_idx  = sidx_r - SW'(3);
  assign retry_inc = retry_r + 4'd1;
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_raddr = data_idx[AW-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    fill_nxt     = fill_r;
    sidx_nxt     = sidx_r;
    blk_nxt      = blk_r;
    sum_nxt      = sum_r;
    retry_nxt    = retry_r;
    final_nxt    = final_r;
    eot_nxt      = eot_r;
    err_nxt      = err_r;
    ack_nxt      = ack_r;
    resend_nxt   = resend_r;
    sent_nxt     = sent_r;
    pad_hold_nxt = pad_hold_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    res          = '0;

    if (in_fire) begin
      unique case (in_command)
        xcs_pkg::CMD_START: begin
          if (phase_r == xcs_pkg::PH_IDLE || phase_r == xcs_pkg::PH_DONE ||
              phase_r == xcs_pkg::PH_ERROR) begin
            fill_nxt   = '0;
            sidx_nxt   = '0;
            sum_nxt    = '0;
            blk_nxt    = 8'd1;
            retry_nxt  = '0;
            final_nxt  = 1'b0;
            eot_nxt    = 1'b0;
            err_nxt    = xcs_pkg::ERR_NONE;
            ack_nxt    = '0;
            resend_nxt = '0;
            sent_nxt   = '0;
            res.tx_valid = 1'b1;
            res.tx_byte  = start_value_r;
            phase_nxt  = xcs_pkg::PH_WAIT_START;
          end
        end
        xcs_pkg::CMD_REPLY: begin
          if (phase_r == xcs_pkg::PH_WAIT_START) begin
            if (in_data_byte == xcs_pkg::NAK_BYTE) begin
              fill_nxt  = '0;
              sidx_nxt  = '0;
              sum_nxt   = '0;
              phase_nxt = xcs_pkg::PH_LOAD;
            end
          end else if (phase_r == xcs_pkg::PH_WAIT_REPLY) begin
            priority if (in_data_byte == xcs_pkg::ACK_BYTE) begin
              ack_nxt   = xcs_pkg::sat_inc(ack_r);
              retry_nxt = '0;
              blk_nxt   = (blk_r == 8'd255) ? 8'd1 : blk_r + 8'd1;
              fill_nxt  = '0;
              sidx_nxt  = '0;
              sum_nxt   = '0;
              if (final_r) begin
                eot_nxt   = 1'b1;
                phase_nxt = xcs_pkg::PH_SEND;
              end else begin
                phase_nxt = xcs_pkg::PH_LOAD;
              end
            end else if (in_data_byte == xcs_pkg::NAK_BYTE) begin
              resend_nxt = xcs_pkg::sat_inc(resend_r);
              retry_nxt  = retry_inc;
              if (retry_inc >= retry_limit_r) begin
                err_nxt   = xcs_pkg::ERR_TRANSFER;
                phase_nxt = xcs_pkg::PH_ERROR;
              end else begin
                sidx_nxt  = '0;
                phase_nxt = xcs_pkg::PH_SEND;
              end
            end else begin
              err_nxt   = xcs_pkg::ERR_TRANSFER;
              phase_nxt = xcs_pkg::PH_ERROR;
            end
          end
        end
        xcs_pkg::CMD_TIMEOUT: begin
          if (phase_r == xcs_pkg::PH_WAIT_START) begin
            err_nxt   = xcs_pkg::ERR_START_TIMEOUT;
            phase_nxt = xcs_pkg::PH_ERROR;
          end else if (phase_r == xcs_pkg::PH_WAIT_REPLY) begin
            err_nxt   = xcs_pkg::ERR_TRANSFER;
            phase_nxt = xcs_pkg::PH_ERROR;
          end
        end
        xcs_pkg::CMD_FILE: begin
          // fill count stays at the real data length; bytes past it read as pad
          if (phase_r == xcs_pkg::PH_LOAD) begin
            mem_we   = 1'b1;
            fill_nxt = fill_inc;
            if (in_final_byte) begin
              final_nxt    = 1'b1;
              pad_hold_nxt = pad_value_r;
              sum_nxt      = sum_add + pad_prod[7:0];
              sidx_nxt     = '0;
              phase_nxt    = xcs_pkg::PH_SEND;
            end else begin
              sum_nxt = sum_add;
              if (fill_inc == FW'(xcs_pkg::BLOCK_BYTES)) begin
                sidx_nxt  = '0;
                phase_nxt = xcs_pkg::PH_SEND;
              end
            end
          end
        end
        xcs_pkg::CMD_SLOT: begin
          if (phase_r == xcs_pkg::PH_SEND) begin
            res.tx_valid = 1'b1;
            priority if (eot_r) begin
              res.tx_byte   = xcs_pkg::EOT_BYTE;
              res.frame_end = 1'b1;
              eot_nxt       = 1'b0;
              phase_nxt     = xcs_pkg::PH_DONE;
            end else if (sidx_r == SW'(0)) begin
              res.tx_byte = xcs_pkg::SOH_BYTE;
              sidx_nxt    = sidx_r + SW'(1);
            end else if (sidx_r == SW'(1)) begin
              res.tx_byte = blk_r;
              sidx_nxt    = sidx_r + SW'(1);
            end else if (sidx_r == SW'(2)) begin
              res.tx_byte = ~blk_r;
              sidx_nxt    = sidx_r + SW'(1);
            end else if (sidx_r < SW'(xcs_pkg::BLOCK_BYTES + 3)) begin
              if (data_idx < SW'(fill_r)) begin
                mem_re      = 1'b1;
                res.sel_mem = 1'b1;
              end else begin
                res.tx_byte = pad_hold_r;
              end
              sidx_nxt = sidx_r + SW'(1);
            end else begin
              res.tx_byte   = sum_r;
              res.frame_end = 1'b1;
              sent_nxt      = xcs_pkg::sat_inc(sent_r);
              sidx_nxt      = '0;
              phase_nxt     = xcs_pkg::PH_WAIT_REPLY;
            end
          end
        end
        default: ;
      endcase
    end

    res.status     = xcs_pkg::status_of(phase_nxt);
    res.error_kind = err_nxt;
    res.acked      = ack_nxt;
    res.resent     = resend_nxt;
    res.sent       = sent_nxt;
  end

  assign p1_v_nxt      = in_fire || (p1_v_r && !p1_adv);
  assign out_valid_nxt = p1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= xcs_pkg::RETRY_LIMIT_RST;
      pad_value_r   <= xcs_pkg::PAD_VALUE_RST;
      start_value_r <= xcs_pkg::START_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xcs_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[3:0];
        xcs_pkg::CFG_PAD_VALUE:   pad_value_r   <= cfg_data;
        xcs_pkg::CFG_START_VALUE: start_value_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= xcs_pkg::PH_IDLE;
      fill_r      <= '0;
      sidx_r      <= '0;
      blk_r       <= 8'd1;
      sum_r       <= '0;
      retry_r     <= '0;
      final_r     <= 1'b0;
      eot_r       <= 1'b0;
      err_r       <= xcs_pkg::ERR_NONE;
      ack_r       <= '0;
      resend_r    <= '0;
      sent_r      <= '0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      sidx_r      <= sidx_nxt;
      blk_r       <= blk_nxt;
      sum_r       <= sum_nxt;
      retry_r     <= retry_nxt;
      final_r     <= final_nxt;
      eot_r       <= eot_nxt;
      err_r       <= err_nxt;
      ack_r       <= ack_nxt;
      resend_r    <= resend_nxt;
      sent_r      <= sent_nxt;
      p1_v_r      <= p1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_hold_r <= pad_hold_nxt;
  end

  // writes only in loading, reads only in sending: no same-entry overlap to forward
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_data_byte;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_r <= res;
    end
    if (p1_adv) begin
      out_tx_valid      <= p1_r.tx_valid;
      out_tx_value      <= p1_r.sel_mem ? rd_r : p1_r.tx_byte;
      out_frame_end     <= p1_r.frame_end;
      out_status        <= p1_r.status;
      out_error_kind    <= p1_r.error_kind;
      out_blocks_acked  <= p1_r.acked;
      out_blocks_resent <= p1_r.resent;
      out_blocks_sent   <= p1_r.sent;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == xcs_pkg::PH_LOAD) |-> (fill_r < FW'(xcs_pkg::BLOCK_BYTES)))
    else $error("loading with a full block buffer");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("block buffer written and read in the same cycle");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (p1_v_r && p1_r.sel_mem && p1_r.tx_valid))
    else $error("buffer read without a matching result in flight");
`endif

endmodule
